/* hdl/gyri_pkg.sv */
package gyri_pkg;

  // Field layout of the SPI response word.
  localparam int RATE_LSB = 10;
  localparam int RATE_W   = 16;

  // Restoring divider: one quotient bit per step over the 64-bit sum.
  localparam int           DIV_STEPS = 64;
  localparam int           DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [63:0]  SIGN64    = 64'h8000_0000_0000_0000;

  localparam logic [31:0] WARM_UP_RESET = 32'd1000000;
  localparam logic [31:0] CAL_END_RESET = 32'd6000000;

  // Configuration register indexes (paddr[2]).
  localparam logic REG_WARM_UP = 1'b0;
  localparam logic REG_CAL_END = 1'b1;

  // Result phase codes.
  localparam logic [1:0] PH_WARM  = 2'd0;
  localparam logic [1:0] PH_CAL   = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;
  localparam logic [1:0] PH_RESET = 2'd3;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLEAR,
    OP_MUL_CAL,
    OP_ADD_BIAS,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_RATE,
    OP_MUL_RUN,
    OP_ADD_ANGLE,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_IN,
    BR_KIND,
    BR_WARM,
    BR_RUN,
    BR_DEN0,
    BR_DIV,
    BR_OUT
  } br_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    op_t   op;
    br_t   br;
    step_t target;
  } ctrl_t;

  // Program labels.
  localparam step_t L_IDLE     = 4'd0;
  localparam step_t L_DISPATCH = 4'd1;
  localparam step_t L_CAL      = 4'd4;
  localparam step_t L_DIV      = 4'd7;
  localparam step_t L_RUN      = 4'd9;
  localparam step_t L_CLR      = 4'd14;
  localparam step_t L_EMIT     = 4'd15;

  // Microcode store: one control word per step.
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    case (s)
      4'd0:  c = '{OP_NOP,       BR_IN,     L_DISPATCH};
      4'd1:  c = '{OP_NOP,       BR_KIND,   L_CLR};
      4'd2:  c = '{OP_NOP,       BR_WARM,   L_EMIT};
      4'd3:  c = '{OP_NOP,       BR_RUN,    L_RUN};
      4'd4:  c = '{OP_MUL_CAL,   BR_NEXT,   L_IDLE};
      4'd5:  c = '{OP_ADD_BIAS,  BR_DEN0,   L_EMIT};
      4'd6:  c = '{OP_DIV_INIT,  BR_NEXT,   L_IDLE};
      4'd7:  c = '{OP_DIV_STEP,  BR_DIV,    L_DIV};
      4'd8:  c = '{OP_DIV_DONE,  BR_ALWAYS, L_EMIT};
      4'd9:  c = '{OP_RATE,      BR_NEXT,   L_IDLE};
      4'd10: c = '{OP_MUL_CAL,   BR_NEXT,   L_IDLE};
      4'd11: c = '{OP_ADD_BIAS,  BR_NEXT,   L_IDLE};
      4'd12: c = '{OP_MUL_RUN,   BR_NEXT,   L_IDLE};
      4'd13: c = '{OP_ADD_ANGLE, BR_ALWAYS, L_EMIT};
      4'd14: c = '{OP_CLEAR,     BR_NEXT,   L_IDLE};
      4'd15: c = '{OP_EMIT,      BR_OUT,    L_IDLE};
      default: c = '{OP_NOP,     BR_ALWAYS, L_IDLE};
    endcase
    return c;
  endfunction

endpackage

/* hdl/gyri_sample_if.sv */
interface gyri_sample_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] response_word;
  logic [31:0] time_us;

  modport source (output valid, kind, response_word, time_us, input ready);
  modport sink (input valid, kind, response_word, time_us, output ready);
endinterface

/* hdl/gyri_result_if.sv */
interface gyri_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         phase;
  logic signed [32:0] rate_q16;
  logic signed [63:0] angle_acc;
  logic signed [31:0] bias_q16;

  modport source (output valid, phase, rate_q16, angle_acc, bias_q16, input ready);
  modport sink (input valid, phase, rate_q16, angle_acc, bias_q16, output ready);
endinterface

/* hdl/gyro_rate_integrator_with_calibration.sv */
// Channel   Dir  Handshake        Payload
// samples   in   valid/ready      kind, response_word, time_us
// results   out  valid/ready      phase, rate_q16, angle_acc, bias_q16
// apb       in   psel/penable     paddr, pwdata, prdata (pready tied high)
//
// One item is processed at a time by a 16-step microprogram; samples.ready is high
// only at the idle step. A calibrating sample with calibration time elapsed also
// runs the restoring divider, which retires one quotient bit per cycle.
// The result register lets the next sample be taken while a result waits; the
// program stalls at its final step only if the previous result is still held.
// rst is synchronous and returns state and configuration to their reset values.
module gyro_rate_integrator_with_calibration import gyri_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gyri_sample_if.sink samples,
  gyri_result_if.source results
);

  logic [31:0] warm_up_us;
  logic [31:0] calibrate_end_us;
  logic        cfg_wr;

  step_t step;
  step_t step_next;
  ctrl_t ctrl;

  logic        kind_r;
  logic [15:0] raw_r;
  logic [31:0] t_r;

  logic [31:0]        last_time;
  logic [63:0]        bias_sum;
  logic signed [31:0] bias_value;
  logic [63:0]        angle_sum;
  logic signed [32:0] rate_now;

  logic [63:0] prod;
  logic        prod_neg;

  logic [63:0]          div_q;
  logic [31:0]          div_rem;
  logic [31:0]          div_den;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 div_neg;

  logic               out_valid;
  logic [1:0]         out_phase;
  logic signed [32:0] out_rate;
  logic signed [63:0] out_angle;
  logic signed [31:0] out_bias;

  logic        in_fire;
  logic        out_free;
  logic [32:0] dt;
  logic [32:0] dt_neg;
  logic [31:0] dt_mag;
  logic [15:0] raw_mag;
  logic [32:0] raw_q16;
  logic [32:0] rate_calc;
  logic [32:0] rate_mag;
  logic [32:0] mul_a;
  logic [64:0] mul_p;
  logic [63:0] mul_res;
  logic        mul_neg;
  logic [63:0] sat_u;
  logic [64:0] sat_sum;
  logic [64:0] sat_diff;
  logic [63:0] sat_res;
  logic [31:0] den;
  logic [63:0] bias_mag;
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [32:0] rem_sub;
  logic [63:0] q_neg;
  logic [1:0]  phase_calc;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_CAL_END) ? calibrate_end_us : warm_up_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_up_us       <= WARM_UP_RESET;
      calibrate_end_us <= CAL_END_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WARM_UP: warm_up_us       <= pwdata;
        REG_CAL_END: calibrate_end_us <= pwdata;
        default: ;
      endcase
    end
  end

  assign ctrl          = ucode(step);
  assign samples.ready = (step == L_IDLE);
  assign in_fire       = samples.valid & samples.ready;
  assign out_free      = ~out_valid | results.ready;

  assign results.valid     = out_valid;
  assign results.phase     = out_phase;
  assign results.rate_q16  = out_rate;
  assign results.angle_acc = out_angle;
  assign results.bias_q16  = out_bias;

  // Operand preparation for the shared multiplier.
  assign dt      = {1'b0, t_r} - {1'b0, last_time};
  assign dt_neg  = ~dt + 33'd1;
  assign dt_mag  = dt[32] ? dt_neg[31:0] : dt[31:0];
  assign raw_mag = raw_r[15] ? (~raw_r + 16'd1) : raw_r;
  assign raw_q16 = {raw_r[15], raw_r, 16'b0};
  assign rate_calc = raw_q16 - {bias_value[31], bias_value};
  assign rate_mag  = rate_now[32] ? (~rate_now + 33'd1) : rate_now;

  always_comb begin
    if (ctrl.op == OP_MUL_RUN) begin
      mul_a   = rate_mag;
      mul_neg = rate_now[32] ^ dt[32];
    end else begin
      mul_a   = {17'b0, raw_mag};
      mul_neg = raw_r[15] ^ dt[32];
    end
    mul_p = 65'(mul_a) * 65'(dt_mag);
    // The raw rate is Q16.16, so the calibration product carries 16 zero bits.
    mul_res = (ctrl.op == OP_MUL_RUN) ? mul_p[63:0] : {mul_p[47:0], 16'b0};
  end

  // Saturating accumulate in offset binary, shared by both sums.
  always_comb begin
    sat_u    = ((ctrl.op == OP_ADD_ANGLE) ? angle_sum : bias_sum) ^ SIGN64;
    sat_sum  = {1'b0, sat_u} + {1'b0, prod};
    sat_diff = {1'b0, sat_u} - {1'b0, prod};
    if (prod_neg) begin
      sat_res = (sat_diff[64] ? 64'd0 : sat_diff[63:0]) ^ SIGN64;
    end else begin
      sat_res = (sat_sum[64] ? {64{1'b1}} : sat_sum[63:0]) ^ SIGN64;
    end
  end

  // Divider helpers.
  assign den      = t_r - warm_up_us;
  assign bias_mag = bias_sum[63] ? (~bias_sum + 64'd1) : bias_sum;
  assign rem_sh   = {div_rem, div_q[63]};
  assign div_ge   = (rem_sh >= {1'b0, div_den});
  assign rem_sub  = rem_sh - {1'b0, div_den};
  assign q_neg    = ~div_q + 64'd1;

  always_comb begin
    if (kind_r) begin
      phase_calc = PH_RESET;
    end else if (t_r < warm_up_us) begin
      phase_calc = PH_WARM;
    end else if (t_r < calibrate_end_us) begin
      phase_calc = PH_CAL;
    end else begin
      phase_calc = PH_RUN;
    end
  end

  // Sequencer branch resolution.
  always_comb begin
    case (ctrl.br)
      BR_NEXT:   step_next = step + 4'd1;
      BR_ALWAYS: step_next = ctrl.target;
      BR_IN:     step_next = in_fire ? ctrl.target : step;
      BR_KIND:   step_next = kind_r ? ctrl.target : step + 4'd1;
      BR_WARM:   step_next = (t_r < warm_up_us) ? ctrl.target : step + 4'd1;
      BR_RUN:    step_next = (t_r >= calibrate_end_us) ? ctrl.target : step + 4'd1;
      BR_DEN0:   step_next = (den == 32'd0) ? ctrl.target : step + 4'd1;
      BR_DIV:    step_next = (div_cnt == DIV_CNT_W'(1)) ? step + 4'd1 : ctrl.target;
      BR_OUT:    step_next = out_free ? ctrl.target : step;
      default:   step_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= L_IDLE;
      out_valid  <= 1'b0;
      div_cnt    <= '0;
      last_time  <= '0;
      bias_sum   <= '0;
      bias_value <= '0;
      angle_sum  <= '0;
      rate_now   <= '0;
    end else begin
      step <= step_next;
      // The emit step loads the result register itself when it is free.
      if (out_valid && results.ready && ctrl.op != OP_EMIT) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        kind_r <= samples.kind;
        raw_r  <= samples.response_word[RATE_LSB +: RATE_W];
        t_r    <= samples.time_us;
      end
      case (ctrl.op)
        OP_CLEAR: begin
          last_time  <= '0;
          bias_sum   <= '0;
          bias_value <= '0;
          angle_sum  <= '0;
          rate_now   <= '0;
        end
        OP_MUL_CAL, OP_MUL_RUN: begin
          prod     <= mul_res;
          prod_neg <= mul_neg;
        end
        OP_ADD_BIAS:  bias_sum  <= sat_res;
        OP_ADD_ANGLE: angle_sum <= sat_res;
        OP_RATE:      rate_now  <= rate_calc;
        OP_DIV_INIT: begin
          div_q   <= bias_mag;
          div_rem <= '0;
          div_den <= den;
          div_neg <= bias_sum[63];
          div_cnt <= DIV_CNT_W'(DIV_STEPS);
        end
        OP_DIV_STEP: begin
          div_rem <= div_ge ? rem_sub[31:0] : rem_sh[31:0];
          div_q   <= {div_q[62:0], div_ge};
          div_cnt <= div_cnt - DIV_CNT_W'(1);
        end
        OP_DIV_DONE: begin
          if (div_neg) begin
            bias_value <= (div_q > 64'h8000_0000) ? 32'sh8000_0000 : q_neg[31:0];
          end else begin
            bias_value <= (div_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : div_q[31:0];
          end
        end
        OP_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_phase <= phase_calc;
            out_rate  <= rate_now;
            out_angle <= angle_sum;
            out_bias  <= bias_value;
            if (!kind_r) begin
              last_time <= t_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

/* hdl/gyri_checker.sv */
module gyri_checker import gyri_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_phase,
  input logic [32:0] out_rate,
  input logic [63:0] out_angle,
  input logic [31:0] out_bias
);

  // Nothing is presented right after reset.
  a_rst_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // The sequencer works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  // A reset item reports cleared state.
  a_reset_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_phase == PH_RESET |-> out_rate == '0 && out_angle == '0 && out_bias == '0)
    else $error("reset result carries nonzero state");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_angle) && $stable(out_phase))
    else $error("stalled result changed");

endmodule

bind gyro_rate_integrator_with_calibration gyri_checker u_gyri_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_phase (results.phase),
  .out_rate  (results.rate_q16),
  .out_angle (results.angle_acc),
  .out_bias  (results.bias_q16)
);

/* dv/testbench.sv */
module testbench;
  import gyri_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SET_ITEMS   = 240;
  localparam int N_SETS      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    logic [1:0]  phase;
    logic [32:0] rate;
    logic [63:0] angle;
    logic [31:0] bias;
  } gyro_result_t;

  // Tracks calibration and integration state and holds the results still owed.
  class angle_tracker;
    logic [31:0]        warm_up_us;
    logic [31:0]        cal_end_us;
    logic [31:0]        last_time;
    logic [63:0]        bias_sum;
    logic [63:0]        angle_sum;
    logic signed [31:0] bias_value;
    logic signed [32:0] rate_now;
    gyro_result_t       due_results[$];
    int unsigned        mismatches;

    function new();
      warm_up_us = WARM_UP_RESET;
      cal_end_us = CAL_END_RESET;
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      last_time  = '0;
      bias_sum   = '0;
      angle_sum  = '0;
      bias_value = '0;
      rate_now   = '0;
    endfunction

    function void set_config(logic idx, logic [31:0] value);
      if (idx == REG_WARM_UP) warm_up_us = value;
      else cal_end_us = value;
    endfunction

    function void note_mismatch(string msg);
      if (mismatches < 10) $display("%s", msg);
      mismatches++;
    endfunction

    // acc += a * b, saturating at the 64-bit signed bounds.
    function logic [63:0] sat_mac(logic [63:0] acc, logic signed [32:0] a,
                                  logic signed [32:0] b);
      logic [32:0] ma;
      logic [32:0] mb;
      logic [63:0] m;
      logic [63:0] u;
      logic [64:0] s;
      logic        neg;
      ma  = a[32] ? -a : a;
      mb  = b[32] ? -b : b;
      m   = 64'(ma) * 64'(mb);
      neg = a[32] ^ b[32];
      // Offset binary turns both bounds into plain unsigned limits.
      u = acc ^ SIGN64;
      if (!neg) begin
        s = {1'b0, u} + {1'b0, m};
        u = s[64] ? '1 : s[63:0];
      end else begin
        u = (m > u) ? '0 : u - m;
      end
      return u ^ SIGN64;
    endfunction

    function void take_sample(logic kind, logic [31:0] word, logic [31:0] t);
      logic signed [15:0] raw;
      logic signed [32:0] raw_q16;
      logic signed [32:0] dt;
      logic [31:0]        den;
      logic [63:0]        mg;
      logic [63:0]        q;
      gyro_result_t       r;
      if (kind) begin
        clear_state();
        r.phase = PH_RESET;
      end else begin
        raw     = word[RATE_LSB +: RATE_W];
        raw_q16 = 33'(raw) * 65536;
        dt      = $signed({1'b0, t}) - $signed({1'b0, last_time});
        if (t < warm_up_us) begin
          r.phase = PH_WARM;
        end else if (t < cal_end_us) begin
          r.phase  = PH_CAL;
          den      = t - warm_up_us;
          bias_sum = sat_mac(bias_sum, raw_q16, dt);
          // With no calibration time elapsed the bias keeps its old value.
          if (den != 0) begin
            mg = bias_sum[63] ? -bias_sum : bias_sum;
            q  = mg / {32'h0, den};
            if (bias_sum[63]) bias_value = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
            else bias_value = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
          end
        end else begin
          r.phase   = PH_RUN;
          rate_now  = raw_q16 - 33'(bias_value);
          bias_sum  = sat_mac(bias_sum, raw_q16, dt);
          angle_sum = sat_mac(angle_sum, rate_now, dt);
        end
        last_time = t;
      end
      r.rate  = rate_now;
      r.angle = angle_sum;
      r.bias  = bias_value;
      due_results.push_back(r);
    endfunction

    function void check_result(gyro_result_t got);
      gyro_result_t want;
      if (due_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: phase %0d rate %h angle %h bias %h",
                                got.phase, got.rate, got.angle, got.bias));
        return;
      end
      want = due_results.pop_front();
      if (got.phase !== want.phase || got.rate !== want.rate ||
          got.angle !== want.angle || got.bias !== want.bias) begin
        note_mismatch($sformatf({"result mismatch (expected/actual): phase %0d/%0d ",
                                 "rate %h/%h angle %h/%h bias %h/%h"},
                                want.phase, got.phase, want.rate, got.rate,
                                want.angle, got.angle, want.bias, got.bias));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gyri_sample_if samples_if();
  gyri_result_if results_if();

  gyro_rate_integrator_with_calibration dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .samples (samples_if),
    .results (results_if)
  );

  angle_tracker tracker;
  int           src_idle_pct  = 0;
  int           snk_stall_pct = 0;
  int           hold_left     = 0;
  int unsigned  cycle_count   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    results_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        results_if.ready <= 1'b0;
      end else begin
        results_if.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : monitor
    gyro_result_t got;
    if (!rst) begin
      if (samples_if.valid && samples_if.ready)
        tracker.take_sample(samples_if.kind, samples_if.response_word, samples_if.time_us);
      if (results_if.valid && results_if.ready) begin
        got.phase = results_if.phase;
        got.rate  = results_if.rate_q16;
        got.angle = results_if.angle_acc;
        got.bias  = results_if.bias_q16;
        tracker.check_result(got);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** gyro_rate_integrator_with_calibration: FAILED **");
      $finish;
    end
  end

  function automatic logic [31:0] with_rate(logic [15:0] rate);
    logic [31:0] w;
    w = $urandom();
    w[RATE_LSB +: RATE_W] = rate;
    return w;
  endfunction

  task automatic send_sample(input logic kind, input logic [31:0] word, input logic [31:0] t);
    while ($urandom_range(99) < src_idle_pct) begin
      @(negedge clk);
      samples_if.valid <= 1'b0;
    end
    @(negedge clk);
    samples_if.valid         <= 1'b1;
    samples_if.kind          <= kind;
    samples_if.response_word <= word;
    samples_if.time_us       <= t;
    do @(posedge clk); while (!samples_if.ready);
  endtask

  task automatic rate_at(input logic [15:0] rate, input logic [31:0] t);
    send_sample(1'b0, with_rate(rate), t);
  endtask

  task automatic reset_item();
    send_sample(1'b1, $urandom(), $urandom());
  endtask

  task automatic drain_results();
    @(negedge clk);
    samples_if.valid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
  endtask

  // Write a register, then read it back.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.set_config(idx, value);
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value)
      tracker.note_mismatch($sformatf("register %0d read back %h, expected %h",
                                      idx, prdata, value));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_set(input int set_idx, input logic [31:0] warm, input logic [31:0] cal_end);
    int          items;
    int          len;
    bit          held;
    bit          paused;
    longint      t;
    longint      nt;
    longint      span;
    longint      scale;
    logic [15:0] center;
    logic [15:0] rate;
    drain_results();
    case (set_idx % 4)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 53; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 53; end
      default: begin src_idle_pct = 11; snk_stall_pct = 11; end
    endcase
    write_reg(REG_WARM_UP, warm);
    write_reg(REG_CAL_END, cal_end);
    items  = 0;
    held   = 0;
    paused = 0;
    t      = 0;
    span   = (warm > cal_end) ? warm : cal_end;
    scale  = span / 12 + 1;
    while (items < SET_ITEMS) begin
      if (set_idx == 0 && items >= 100 && !held) begin
        hold_left = HOLD_CYCLES;
        held = 1;
      end
      if (set_idx == 2 && items >= 120 && !paused) begin
        drain_results();
        paused = 1;
      end
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(3))
          0: send_sample(1'($urandom_range(1)), $urandom(), $urandom());
          1: send_sample(1'b0, $urandom(), warm);
          2: send_sample(1'b0, $urandom(), cal_end);
          default: send_sample(1'b0, $urandom(), 32'(t - $urandom_range(50)));
        endcase
        items++;
      end else begin
        // Usually a reset first, then time mostly moving forward through the phases.
        if ($urandom_range(4) != 0) begin
          reset_item();
          t = 0;
          items++;
        end
        center = 16'($urandom_range(400)) - 16'd200;
        len = $urandom_range(40, 5);
        repeat (len) begin
          case ($urandom_range(19))
            0: t = warm;
            1: t = (warm == 0) ? 0 : warm - 1;
            2: t = cal_end;
            3: ;
            default: begin
              nt = t + $urandom_range(32'(scale));
              t = (nt > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : nt;
            end
          endcase
          case ($urandom_range(9))
            0: rate = 16'h7FFF;
            1: rate = 16'h8000;
            2: rate = 16'($urandom());
            default: rate = center + 16'($urandom_range(64)) - 16'd32;
          endcase
          rate_at(rate, 32'(t));
          items++;
        end
      end
    end
  endtask

  initial begin
    logic [31:0] warm;
    logic [31:0] cal_end;
    tracker = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    samples_if.valid = 1'b0;
    samples_if.kind = 1'b0;
    samples_if.response_word = '0;
    samples_if.time_us = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset-value windows: every phase, its boundaries, zero calibration time.
    reset_item();
    rate_at(16'h7FFF, 32'd0);
    rate_at(16'h8000, 32'd999999);
    rate_at(16'h7FFF, 32'd1000000);
    rate_at(16'h8000, 32'd1000001);
    rate_at(16'h1234, 32'd3000000);
    rate_at(16'hFFFF, 32'd5999999);
    rate_at(16'h7FFF, 32'd6000000);
    rate_at(16'h8000, 32'hFFFF_FFFF);

    // No calibration phase; huge forward and backward steps drive the angle
    // into both saturation limits.
    drain_results();
    write_reg(REG_WARM_UP, 32'd0);
    write_reg(REG_CAL_END, 32'd0);
    reset_item();
    rate_at(16'h7FFF, 32'hFFFF_FFFF);
    rate_at(16'h8000, 32'd0);
    rate_at(16'h8000, 32'hFFFF_FFFF);
    rate_at(16'h7FFF, 32'd0);
    rate_at(16'h8000, 32'hFFFF_FFFF);

    // A one-microsecond calibration time after a large backward step
    // saturates the bias; a run sample and a zero-calibration-time sample follow.
    drain_results();
    write_reg(REG_WARM_UP, 32'd1);
    write_reg(REG_CAL_END, 32'hFFFF_FFFF);
    reset_item();
    rate_at(16'h7FFF, 32'd0);
    rate_at(16'h7FFF, 32'hFFFF_FFF0);
    rate_at(16'h7FFF, 32'd2);
    rate_at(16'h7FFF, 32'hFFFF_FFFF);
    rate_at(16'h8000, 32'd1);

    for (int i = 0; i < N_SETS; i++) begin
      case (i)
        0: begin warm = 32'd100;         cal_end = 32'd400;         end
        1: begin warm = 32'd0;           cal_end = 32'd0;           end
        2: begin warm = 32'd300;         cal_end = 32'd100;         end
        3: begin warm = 32'd0;           cal_end = 32'hFFFF_FFFF;   end
        4: begin warm = 32'hFFFF_FFFF;   cal_end = 32'hFFFF_FFFF;   end
        5: begin warm = 32'd50;          cal_end = 32'd51;          end
        6: begin
          warm    = $urandom_range(5000);
          cal_end = warm + $urandom_range(20000);
        end
        default: begin warm = WARM_UP_RESET; cal_end = CAL_END_RESET; end
      endcase
      run_set(i, warm, cal_end);
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
      $display("** gyro_rate_integrator_with_calibration: PASSED **");
    else
      $display("** gyro_rate_integrator_with_calibration: FAILED **");
    $finish;
  end

endmodule
